### rtl/wall_follow_pid_steering_macros.svh
// Assertion helpers shared by the RTL modules.
// Every helper samples on the rising edge of clk and is off while rst_n is low.
`ifndef WALL_FOLLOW_PID_STEERING_MACROS_SVH
`define WALL_FOLLOW_PID_STEERING_MACROS_SVH

// The condition must hold at every clock edge.
`define WFPS_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequence must hold in the same cycle as the antecedent.
`define WFPS_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequence must hold in the cycle after the antecedent.
`define WFPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/wfps_pkg.sv
package wfps_pkg;

    // Field widths.
    localparam int RangeW  = 16;
    localparam int ErrW    = 17;
    localparam int SumW    = 21;
    localparam int DiffW   = 18;
    localparam int GainW   = 32;
    localparam int HeadW   = 24;
    localparam int SpeedW  = 11;
    localparam int SideW   = 2;
    localparam int ILimW   = 20;
    localparam int DLimW   = 23;
    localparam int AddrW   = 5;
    localparam int DataW   = 32;
    localparam int InDataW = 32;
    localparam int OutDataW = 40;

    // Range thresholds in millimeters.
    localparam logic [RangeW-1:0] LowEdge     = 16'd249;
    localparam logic [RangeW-1:0] HighEdge    = 16'd1501;
    localparam logic [RangeW-1:0] ReleaseEdge = 16'd999;
    localparam logic [RangeW-1:0] FollowEdge  = 16'd1000;

    // Heading change saturation limits.
    localparam int HeadMax = 8388607;
    localparam int HeadMin = -8388608;

    // Wall side reported with each command.
    typedef enum logic [SideW-1:0] {
        SIDE_STRAIGHT = 2'd0,
        SIDE_LEFT     = 2'd1,
        SIDE_RIGHT    = 2'd2
    } side_t;

    // Register indexes on the configuration port.
    typedef enum logic [2:0] {
        REG_SET_POINT        = 3'd0,
        REG_P_GAIN           = 3'd1,
        REG_I_GAIN           = 3'd2,
        REG_D_GAIN           = 3'd3,
        REG_INTEGRAL_LIMIT   = 3'd4,
        REG_DERIVATIVE_LIMIT = 3'd5,
        REG_CRUISE_SPEED     = 3'd6
    } reg_idx_t;

    // Configuration handed from the register file to the datapath.
    typedef struct packed {
        logic [RangeW-1:0]       set_point;
        logic signed [GainW-1:0] p_gain;
        logic signed [GainW-1:0] i_gain;
        logic signed [GainW-1:0] d_gain;
        logic [ILimW-1:0]        integral_limit;
        logic [DLimW-1:0]        derivative_limit;
        logic [SpeedW-1:0]       cruise_speed;
    } cfg_t;

    localparam cfg_t CfgReset = '{
        set_point:        16'd700,
        p_gain:           32'sd3187671,
        i_gain:           32'sd1678,
        d_gain:           -32'sd58720256,
        integral_limit:   20'd800,
        derivative_limit: 23'd6400,
        cruise_speed:     11'd200
    };

endpackage

### rtl/wfps_regs.sv
module wfps_regs
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [wfps_pkg::AddrW-1:0]   paddr,
    input  logic [wfps_pkg::DataW-1:0]   pwdata,
    output logic [wfps_pkg::DataW-1:0]   prdata,
    output logic                         pready,
    output wfps_pkg::cfg_t               cfg
);

    wfps_pkg::cfg_t     cfg_reg;
    wfps_pkg::reg_idx_t reg_idx;
    logic               wr_en;

    assign reg_idx = wfps_pkg::reg_idx_t'(paddr[4:2]);
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    // Register writes take the low bits of the write data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= wfps_pkg::CfgReset;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                wfps_pkg::REG_SET_POINT:        cfg_reg.set_point        <= pwdata[15:0];
                wfps_pkg::REG_P_GAIN:           cfg_reg.p_gain           <= $signed(pwdata);
                wfps_pkg::REG_I_GAIN:           cfg_reg.i_gain           <= $signed(pwdata);
                wfps_pkg::REG_D_GAIN:           cfg_reg.d_gain           <= $signed(pwdata);
                wfps_pkg::REG_INTEGRAL_LIMIT:   cfg_reg.integral_limit   <= pwdata[19:0];
                wfps_pkg::REG_DERIVATIVE_LIMIT: cfg_reg.derivative_limit <= pwdata[22:0];
                wfps_pkg::REG_CRUISE_SPEED:     cfg_reg.cruise_speed     <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    // Read data mux; unused addresses read as zero.
    always_comb
    begin
        case (reg_idx)
            wfps_pkg::REG_SET_POINT:        prdata = {16'd0, cfg_reg.set_point};
            wfps_pkg::REG_P_GAIN:           prdata = cfg_reg.p_gain;
            wfps_pkg::REG_I_GAIN:           prdata = cfg_reg.i_gain;
            wfps_pkg::REG_D_GAIN:           prdata = cfg_reg.d_gain;
            wfps_pkg::REG_INTEGRAL_LIMIT:   prdata = {12'd0, cfg_reg.integral_limit};
            wfps_pkg::REG_DERIVATIVE_LIMIT: prdata = {9'd0, cfg_reg.derivative_limit};
            wfps_pkg::REG_CRUISE_SPEED:     prdata = {21'd0, cfg_reg.cruise_speed};
            default:                        prdata = '0;
        endcase
    end

endmodule

### rtl/wall_follow_pid_steering.sv
// A reading passes through the input register and then the command register to m_tvalid.
// Throughput: one range pair per clock cycle unless m_tready is held low; all the work for a
// reading sits between the input and command registers, so readings can follow back to back.
// Readings outside the active window leave the input register without producing a command.
// Reset (rst_n low, asynchronous) empties both registers, clears the wall flags, the error
// sum and the last error, and returns every configuration register to its default value.
`include "wall_follow_pid_steering_macros.svh"

module wall_follow_pid_steering
(
    input  logic                            clk,
    input  logic                            rst_n,
    // Input stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [wfps_pkg::InDataW-1:0]    s_tdata,   // left_range[15:0], right_range[31:16]
    // Output stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [wfps_pkg::OutDataW-1:0]   m_tdata,   // heading_change[23:0], speed_command[34:24]
    output logic [wfps_pkg::SideW-1:0]      m_tuser,   // side[1:0]
    // Configuration port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [wfps_pkg::AddrW-1:0]      paddr,
    input  logic [wfps_pkg::DataW-1:0]      pwdata,
    output logic [wfps_pkg::DataW-1:0]      prdata,
    output logic                            pready
);

    wfps_pkg::cfg_t cfg;

    wfps_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Flow control: a register loads when it is empty or its content moves on.
    logic s0_valid_reg, out_valid_reg;
    logic out_free, s0_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s0_free  = !s0_valid_reg || out_free;
    assign s_tready = s0_free;

    // Input register.
    logic [wfps_pkg::RangeW-1:0] left_reg, right_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (s0_free)
        begin
            s0_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_free && s_tvalid)
        begin
            left_reg  <= s_tdata[15:0];
            right_reg <= s_tdata[31:16];
        end
    end

    // Window check, wall choice, error and integral with its clamp.
    logic                          follow_left_reg, follow_right_reg;
    logic                          follow_left_next, follow_right_next;
    logic signed [wfps_pkg::SumW-1:0]  error_sum_reg, error_sum_next;
    logic signed [wfps_pkg::ErrW-1:0]  last_error_reg;
    logic                          in_window, state_load;
    logic                          left_kept, right_kept;
    logic signed [wfps_pkg::ErrW-1:0]  err_left, err_right, err;
    logic signed [wfps_pkg::SumW-1:0]  base_sum;
    logic signed [wfps_pkg::ErrW-1:0]  base_last;
    logic signed [wfps_pkg::SumW:0]    sum_wide, ilim_pos, ilim_neg;
    logic signed [wfps_pkg::DiffW-1:0] diff;
    wfps_pkg::side_t               side_next;

    assign in_window = (left_reg > wfps_pkg::LowEdge) && (right_reg > wfps_pkg::LowEdge)
                    && ((left_reg < wfps_pkg::HighEdge) || (right_reg < wfps_pkg::HighEdge));
    assign state_load = s0_valid_reg && out_free && in_window;

    assign err_left  = $signed({1'b0, left_reg}) - $signed({1'b0, cfg.set_point});
    assign err_right = $signed({1'b0, cfg.set_point}) - $signed({1'b0, right_reg});

    // A far range releases that side's flag before the new choice is made.
    assign left_kept  = follow_left_reg && !(left_reg > wfps_pkg::ReleaseEdge);
    assign right_kept = follow_right_reg && !(right_reg > wfps_pkg::ReleaseEdge);

    always_comb
    begin
        follow_left_next  = left_kept;
        follow_right_next = right_kept;
        if ((left_reg < wfps_pkg::FollowEdge) && !right_kept)
        begin
            err               = err_left;
            base_sum          = error_sum_reg;
            base_last         = last_error_reg;
            follow_left_next  = 1'b1;
            side_next         = wfps_pkg::SIDE_LEFT;
        end
        else if ((right_reg < wfps_pkg::FollowEdge) && !left_kept)
        begin
            err               = err_right;
            base_sum          = error_sum_reg;
            base_last         = last_error_reg;
            follow_right_next = 1'b1;
            side_next         = wfps_pkg::SIDE_RIGHT;
        end
        else
        begin
            // No wall in reach: the controller history starts over.
            err       = '0;
            base_sum  = '0;
            base_last = '0;
            side_next = wfps_pkg::SIDE_STRAIGHT;
        end
    end

    // Integral update with symmetric clamp.
    assign sum_wide = (wfps_pkg::SumW+1)'(base_sum) + (wfps_pkg::SumW+1)'(err);
    assign ilim_pos = $signed({2'b00, cfg.integral_limit});
    assign ilim_neg = -ilim_pos;

    always_comb
    begin
        if (sum_wide > ilim_pos)
        begin
            error_sum_next = ilim_pos[wfps_pkg::SumW-1:0];
        end
        else if (sum_wide < ilim_neg)
        begin
            error_sum_next = ilim_neg[wfps_pkg::SumW-1:0];
        end
        else
        begin
            error_sum_next = sum_wide[wfps_pkg::SumW-1:0];
        end
    end

    assign diff = wfps_pkg::DiffW'(base_last) - wfps_pkg::DiffW'(err);

    // Controller state changes only when an in-window reading is passed on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            follow_left_reg  <= 1'b0;
            follow_right_reg <= 1'b0;
            error_sum_reg    <= '0;
            last_error_reg   <= '0;
        end
        else if (state_load)
        begin
            follow_left_reg  <= follow_left_next;
            follow_right_reg <= follow_right_next;
            error_sum_reg    <= error_sum_next;
            last_error_reg   <= err;
        end
    end

    // The three gain products, each floored to 1/256 degree.
    localparam int PProdW = wfps_pkg::ErrW + wfps_pkg::GainW;
    localparam int IProdW = wfps_pkg::SumW + wfps_pkg::GainW;
    localparam int DProdW = wfps_pkg::DiffW + wfps_pkg::GainW;
    localparam int Shift  = 16;

    logic signed [PProdW-1:0]       p_prod;
    logic signed [IProdW-1:0]       i_prod;
    logic signed [DProdW-1:0]       d_prod;
    logic signed [PProdW-Shift-1:0] p_term;
    logic signed [IProdW-Shift-1:0] i_term;
    logic signed [DProdW-Shift-1:0] d_term;

    assign p_prod = PProdW'(err) * PProdW'(cfg.p_gain);
    assign i_prod = IProdW'(error_sum_next) * IProdW'(cfg.i_gain);
    assign d_prod = DProdW'(diff) * DProdW'(cfg.d_gain);

    // Dropping the low bits of a two's complement product rounds toward minus infinity.
    assign p_term = p_prod[PProdW-1:Shift];
    assign i_term = i_prod[IProdW-1:Shift];
    assign d_term = d_prod[DProdW-1:Shift];

    // Derivative clamp, sum of terms and output saturation.
    localparam int DTermW = DProdW - Shift;
    localparam int TotW   = IProdW - Shift + 2;

    logic signed [DTermW-1:0]         dlim_pos, dlim_neg, d_clamped;
    logic signed [TotW-1:0]           total;
    logic signed [wfps_pkg::HeadW-1:0] heading_next;
    logic signed [wfps_pkg::HeadW-1:0] heading_reg;
    logic [wfps_pkg::SpeedW-1:0]      speed_reg;
    wfps_pkg::side_t                  side_reg;
    logic                             out_load;

    assign dlim_pos = $signed({{(DTermW-wfps_pkg::DLimW){1'b0}}, cfg.derivative_limit});
    assign dlim_neg = -dlim_pos;

    always_comb
    begin
        if (d_term > dlim_pos)
        begin
            d_clamped = dlim_pos;
        end
        else if (d_term < dlim_neg)
        begin
            d_clamped = dlim_neg;
        end
        else
        begin
            d_clamped = d_term;
        end
    end

    assign total = TotW'(p_term) + TotW'(i_term) + TotW'(d_clamped);

    always_comb
    begin
        if (total > TotW'(wfps_pkg::HeadMax))
        begin
            heading_next = wfps_pkg::HeadW'(wfps_pkg::HeadMax);
        end
        else if (total < TotW'(wfps_pkg::HeadMin))
        begin
            heading_next = wfps_pkg::HeadW'(wfps_pkg::HeadMin);
        end
        else
        begin
            heading_next = total[wfps_pkg::HeadW-1:0];
        end
    end

    // Command register.
    assign out_load = s0_valid_reg && in_window && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s0_valid_reg && in_window;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            heading_reg <= heading_next;
            speed_reg   <= cfg.cruise_speed;
            side_reg    <= side_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, speed_reg, heading_reg};
    assign m_tuser  = side_reg;

    // Checks on the controller state and the datapath.
    `WFPS_ASSERT_HOLDS(a_one_wall, !(follow_left_reg && follow_right_reg),
        "both wall flags are set")
    `WFPS_ASSERT_NEXT(a_state_hold, !state_load,
        $stable(error_sum_reg) && $stable(last_error_reg)
            && $stable(follow_left_reg) && $stable(follow_right_reg),
        "controller state changed without an in-window reading")
    `WFPS_ASSERT_IMPLIES(a_straight_reset,
        state_load && (side_next == wfps_pkg::SIDE_STRAIGHT),
        (err == '0) && (error_sum_next == '0) && (diff == '0),
        "straight step carries a nonzero error history")
    `WFPS_ASSERT_IMPLIES(a_sum_bound, state_load,
        ((wfps_pkg::SumW+1)'(error_sum_next) <= ilim_pos)
            && ((wfps_pkg::SumW+1)'(error_sum_next) >= ilim_neg),
        "error sum outside the integral limit")
    `WFPS_ASSERT_IMPLIES(a_straight_out,
        out_valid_reg && (side_reg == wfps_pkg::SIDE_STRAIGHT),
        heading_reg == '0,
        "straight command with a nonzero heading change")

endmodule

### tb/sv/wfps_checker.sv
module wfps_checker
    import wfps_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [InDataW-1:0]   s_tdata,   // left_range[15:0], right_range[31:16]
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [OutDataW-1:0]  m_tdata,   // heading_change[23:0], speed_command[34:24]
    input  logic [SideW-1:0]     m_tuser,   // side[1:0]
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AddrW-1:0]     paddr,
    input  logic [DataW-1:0]     pwdata,
    input  logic                 pready,
    output int                   fail_count,
    output int                   pending,
    output int                   commands_checked,
    output int                   readings_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    // One steering command as it leaves the block.
    typedef struct packed {
        logic signed [HeadW-1:0] heading_change;
        logic [SpeedW-1:0]       speed_command;
        side_t                   side;
    } steer_cmd_t;

    steer_cmd_t expected_cmds[$];
    cfg_t       regs;
    bit         follow_l;
    bit         follow_r;
    longint     err_sum;
    longint     prev_err;
    int         fails;
    int         checked;
    int         seen;

    // Steering law for one range pair. Returns 1 when the pair yields a command.
    function automatic bit predict_command(input logic [RangeW-1:0] left,
                                           input logic [RangeW-1:0] right,
                                           output steer_cmd_t cmd);
        longint err;
        longint sum_lim;
        longint diff_lim;
        longint p_term;
        longint i_term;
        longint d_term;
        longint total;
        side_t  sd;
        cmd = '0;
        // Readings outside the active window are dropped without touching state.
        if (left <= LowEdge || right <= LowEdge)
        begin
            return 1'b0;
        end
        if (left >= HighEdge && right >= HighEdge)
        begin
            return 1'b0;
        end

        // A far reading on a side releases that side's sticky flag.
        if (left > ReleaseEdge)
        begin
            follow_l = 1'b0;
        end
        if (right > ReleaseEdge)
        begin
            follow_r = 1'b0;
        end

        if (left < FollowEdge && !follow_r)
        begin
            err      = longint'(left) - longint'(regs.set_point);
            follow_l = 1'b1;
            sd       = SIDE_LEFT;
        end
        else if (right < FollowEdge && !follow_l)
        begin
            err      = longint'(regs.set_point) - longint'(right);
            follow_r = 1'b1;
            sd       = SIDE_RIGHT;
        end
        else
        begin
            // No wall in reach: the controller history starts over.
            err      = 0;
            prev_err = 0;
            err_sum  = 0;
            sd       = SIDE_STRAIGHT;
        end

        // Integral with symmetric clamp.
        sum_lim = longint'(regs.integral_limit);
        err_sum = err_sum + err;
        if (err_sum > sum_lim)
        begin
            err_sum = sum_lim;
        end
        else if (err_sum < -sum_lim)
        begin
            err_sum = -sum_lim;
        end

        // Q8.24 gains times millimeters, floored down to 1/256 degree.
        p_term = (longint'($signed(regs.p_gain)) * err) >>> 16;
        i_term = (longint'($signed(regs.i_gain)) * err_sum) >>> 16;
        d_term = (longint'($signed(regs.d_gain)) * (prev_err - err)) >>> 16;
        diff_lim = longint'(regs.derivative_limit);
        if (d_term > diff_lim)
        begin
            d_term = diff_lim;
        end
        else if (d_term < -diff_lim)
        begin
            d_term = -diff_lim;
        end
        prev_err = err;

        total = p_term + i_term + d_term;
        if (total > HeadMax)
        begin
            total = HeadMax;
        end
        else if (total < HeadMin)
        begin
            total = HeadMin;
        end

        cmd.heading_change = total[HeadW-1:0];
        cmd.speed_command  = regs.cruise_speed;
        cmd.side           = sd;
        return 1'b1;
    endfunction

    // Track register writes, predict on each input transaction, compare on each output.
    always @(posedge clk or negedge rst_n)
    begin : watch
        steer_cmd_t got;
        steer_cmd_t want;
        steer_cmd_t fresh;
        if (!rst_n)
        begin
            regs     = CfgReset;
            follow_l = 1'b0;
            follow_r = 1'b0;
            err_sum  = 0;
            prev_err = 0;
            fails    = 0;
            checked  = 0;
            seen     = 0;
            expected_cmds.delete();
        end
        else
        begin
            // Register write; an address past the last register is ignored.
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[AddrW-1:2]))
                    REG_SET_POINT:        regs.set_point        = pwdata[RangeW-1:0];
                    REG_P_GAIN:           regs.p_gain           = pwdata[GainW-1:0];
                    REG_I_GAIN:           regs.i_gain           = pwdata[GainW-1:0];
                    REG_D_GAIN:           regs.d_gain           = pwdata[GainW-1:0];
                    REG_INTEGRAL_LIMIT:   regs.integral_limit   = pwdata[ILimW-1:0];
                    REG_DERIVATIVE_LIMIT: regs.derivative_limit = pwdata[DLimW-1:0];
                    REG_CRUISE_SPEED:     regs.cruise_speed     = pwdata[SpeedW-1:0];
                    default: ;
                endcase
            end

            // Output transaction against the oldest prediction.
            if (m_tvalid && m_tready)
            begin
                got.heading_change = m_tdata[HeadW-1:0];
                got.speed_command  = m_tdata[HeadW+SpeedW-1:HeadW];
                got.side           = side_t'(m_tuser);
                checked++;
                if (expected_cmds.size() == 0)
                begin
                    $error("steering command with no prediction pending");
                    fails++;
                end
                else
                begin
                    want = expected_cmds.pop_front();
                    if (got.heading_change !== want.heading_change)
                    begin
                        $error("heading_change mismatch: expected %0d, actual %0d",
                               want.heading_change, got.heading_change);
                        fails++;
                    end
                    if (got.speed_command !== want.speed_command)
                    begin
                        $error("speed_command mismatch: expected %0d, actual %0d",
                               want.speed_command, got.speed_command);
                        fails++;
                    end
                    if (got.side !== want.side)
                    begin
                        $error("side mismatch: expected %0d, actual %0d",
                               want.side, got.side);
                        fails++;
                    end
                end
            end

            // Input transaction: run the steering law.
            if (s_tvalid && s_tready)
            begin
                seen++;
                if (predict_command(s_tdata[RangeW-1:0], s_tdata[2*RangeW-1:RangeW], fresh))
                begin
                    expected_cmds.push_back(fresh);
                end
            end
        end
        fail_count       <= fails;
        pending          <= expected_cmds.size();
        commands_checked <= checked;
        readings_seen    <= seen;
    end

endmodule

### tb/sv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wfps_pkg::*;

    localparam int StallLimit     = 4000;
    localparam int PipeLatency    = 1;
    localparam int HoldOffCycles  = 200;
    localparam int UnusedRegIdx   = 7;
    localparam int PhaseReadings  = 200;
    localparam int BurstReadings  = 50;
    localparam int NumPhases      = 5;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [InDataW-1:0]   s_tdata;   // left_range[15:0], right_range[31:16]
    logic                 m_tvalid;
    logic                 m_tready;
    logic [OutDataW-1:0]  m_tdata;   // heading_change[23:0], speed_command[34:24]
    logic [SideW-1:0]     m_tuser;   // side[1:0]
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [AddrW-1:0]     paddr;
    logic [DataW-1:0]     pwdata;
    logic [DataW-1:0]     prdata;
    logic                 pready;

    int fail_count;
    int pending;
    int commands_checked;
    int readings_seen;

    bit burst_mode;
    bit pressure_req;
    int walk_l;
    int walk_r;

    wall_follow_pid_steering dut (.*);

    wfps_checker steer_chk (.*);

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Stop the run when no channel has moved for too long.
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < StallLimit)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("wall_follow_pid_steering verification failed");
        $finish;
    end

    // Command receiver: random back-pressure, bursts without it, and long hold-offs.
    initial
    begin : receiver
        int wait_cycles;
        m_tready <= 1'b0;
        forever
        begin
            if (pressure_req)
            begin
                pressure_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HoldOffCycles) @(posedge clk);
            end
            wait_cycles = burst_mode ? 0 : $urandom_range(0, 7);
            if (wait_cycles > 0)
            begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // Register write with a setup phase and an access phase.
    task automatic apb_write(input int idx, input logic [DataW-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AddrW'(idx * 4);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Offer one range pair after a random gap and hold it until accepted.
    task automatic send_reading(input logic [RangeW-1:0] l, input logic [RangeW-1:0] r);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {r, l};
        do @(posedge clk); while (!s_tready);
    endtask

    // Let every predicted command arrive, then let dropped readings leave the pipe.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (PipeLatency + 3) @(posedge clk);
    endtask

    // Register settings for each phase of the run.
    task automatic program_phase(input int phase);
        logic [DataW-1:0] vals[7];
        case (phase)
            0:
            begin
                vals[REG_SET_POINT]        = $urandom_range(300, 1200);
                vals[REG_P_GAIN]           = $urandom_range(0, 1 << 27) - (1 << 26);
                vals[REG_I_GAIN]           = $urandom_range(0, 1 << 21) - (1 << 20);
                vals[REG_D_GAIN]           = $urandom_range(0, 1 << 28) - (1 << 27);
                vals[REG_INTEGRAL_LIMIT]   = $urandom_range(0, 5000);
                vals[REG_DERIVATIVE_LIMIT] = $urandom_range(0, 100000);
                vals[REG_CRUISE_SPEED]     = $urandom_range(0, 2000);
            end
            1:
            begin
                vals[REG_SET_POINT]        = 32'd65535;
                vals[REG_P_GAIN]           = 32'h7FFF_FFFF;
                vals[REG_I_GAIN]           = 32'h8000_0000;
                vals[REG_D_GAIN]           = 32'h7FFF_FFFF;
                vals[REG_INTEGRAL_LIMIT]   = 32'd1048575;
                vals[REG_DERIVATIVE_LIMIT] = 32'd8388607;
                vals[REG_CRUISE_SPEED]     = 32'd2000;
            end
            2:
            begin
                vals[REG_SET_POINT]        = 32'd0;
                vals[REG_P_GAIN]           = 32'h8000_0000;
                vals[REG_I_GAIN]           = 32'h7FFF_FFFF;
                vals[REG_D_GAIN]           = 32'h8000_0000;
                vals[REG_INTEGRAL_LIMIT]   = 32'd0;
                vals[REG_DERIVATIVE_LIMIT] = 32'd0;
                vals[REG_CRUISE_SPEED]     = 32'd0;
            end
            3:
            begin
                // Every bit random; the block keeps only the low bits of the narrower registers.
                foreach (vals[i])
                begin
                    vals[i] = $urandom();
                end
            end
            default:
            begin
                vals[REG_SET_POINT]        = DataW'(CfgReset.set_point);
                vals[REG_P_GAIN]           = CfgReset.p_gain;
                vals[REG_I_GAIN]           = CfgReset.i_gain;
                vals[REG_D_GAIN]           = CfgReset.d_gain;
                vals[REG_INTEGRAL_LIMIT]   = DataW'(CfgReset.integral_limit);
                vals[REG_DERIVATIVE_LIMIT] = DataW'(CfgReset.derivative_limit);
                vals[REG_CRUISE_SPEED]     = DataW'(CfgReset.cruise_speed);
            end
        endcase
        foreach (vals[i])
        begin
            apb_write(i, vals[i]);
        end
        apb_write(UnusedRegIdx, $urandom());
    endtask

    // Values right around the window and follow thresholds.
    function automatic logic [RangeW-1:0] border_value();
        case ($urandom_range(0, 7))
            0:       return 16'd249;
            1:       return 16'd250;
            2:       return 16'd998;
            3:       return 16'd999;
            4:       return 16'd1000;
            5:       return 16'd1001;
            6:       return 16'd1500;
            default: return 16'd1501;
        endcase
    endfunction

    // Slow drift of a range, with an occasional jump, kept inside the window.
    function automatic int step_walk(input int w);
        int v;
        if ($urandom_range(0, 19) == 0)
        begin
            return $urandom_range(250, 1500);
        end
        v = w + int'($urandom_range(0, 160)) - 80;
        if (v < 250)
        begin
            v = 250;
        end
        else if (v > 1500)
        begin
            v = 1500;
        end
        return v;
    endfunction

    function automatic bit reading_in_window(input logic [RangeW-1:0] l,
                                             input logic [RangeW-1:0] r);
        return (l > LowEdge) && (r > LowEdge) && ((l < HighEdge) || (r < HighEdge));
    endfunction

    // Mostly drifting wall distances, then one-sided walls, open space, borders and noise.
    task automatic pick_ranges(output logic [RangeW-1:0] l, output logic [RangeW-1:0] r);
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 50)
        begin
            walk_l = step_walk(walk_l);
            walk_r = step_walk(walk_r);
            l = RangeW'(walk_l);
            r = RangeW'(walk_r);
        end
        else if (kind < 65)
        begin
            if ($urandom_range(0, 1) == 1)
            begin
                l = RangeW'($urandom_range(250, 999));
                r = RangeW'($urandom_range(1000, 65535));
            end
            else
            begin
                l = RangeW'($urandom_range(1000, 65535));
                r = RangeW'($urandom_range(250, 999));
            end
        end
        else if (kind < 78)
        begin
            l = RangeW'($urandom_range(1000, 1500));
            r = RangeW'($urandom_range(1000, 1500));
        end
        else if (kind < 88)
        begin
            l = border_value();
            r = border_value();
        end
        else
        begin
            l = RangeW'($urandom());
            r = RangeW'($urandom());
        end
    endtask

    // Stimulus and verdict.
    initial
    begin : stimulus
        logic [RangeW-1:0] l;
        logic [RangeW-1:0] r;
        int sent;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        burst_mode   = 1'b0;
        pressure_req = 1'b0;
        walk_l = 700;
        walk_r = 1200;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed readings with reset settings: window borders, flag hand-over,
        // release of a flag by a far range, and open space on both sides.
        send_reading(16'd250, 16'd1500);
        send_reading(16'd249, 16'd500);
        send_reading(16'd500, 16'd249);
        send_reading(16'd1501, 16'd1501);
        send_reading(16'd1501, 16'd600);
        send_reading(16'd600, 16'd800);
        send_reading(16'd1000, 16'd1000);
        send_reading(16'd999, 16'd999);
        send_reading(16'd65535, 16'd65535);
        send_reading(16'd0, 16'd0);
        send_reading(16'd1500, 16'd1500);
        send_reading(16'd1500, 16'd1501);
        send_reading(16'd1501, 16'd1500);
        send_reading(16'd999, 16'd1000);
        send_reading(16'd1000, 16'd999);
        send_reading(16'd65535, 16'd400);
        send_reading(16'd400, 16'd65535);
        send_reading(16'd250, 16'd250);
        send_reading(16'd998, 16'd300);
        send_reading(16'd300, 16'd998);
        wait_drained();

        // Random phases, each under its own register settings.
        for (int phase = 0; phase < NumPhases; phase++)
        begin
            program_phase(phase);
            sent         = 0;
            burst_mode   = 1'b1;
            pressure_req = (phase == 1) || (phase == 3);
            while (sent < PhaseReadings)
            begin
                if (sent == BurstReadings)
                begin
                    burst_mode = 1'b0;
                end
                pick_ranges(l, r);
                send_reading(l, r);
                if (reading_in_window(l, r))
                begin
                    sent++;
                end
            end
            wait_drained();
        end

        $display("Run covered %0d range readings and %0d checked steering commands,",
                 readings_seen, commands_checked);
        $display("under reset, random, full-scale and zero-limit settings with receiver hold-offs.");
        if (fail_count == 0 && pending == 0)
        begin
            $display("wall_follow_pid_steering verification clean");
        end
        else
        begin
            $display("wall_follow_pid_steering verification failed");
        end
        $finish;
    end

endmodule
